/* rtl/free_list_pool_allocator_unit_defines.svh */
// ----------------------------------------------------------------------------
// free_list_pool_allocator_unit_defines
// assertion macros shared by the pool allocator rtl, clocked on clk
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_POOL_ALLOCATOR_UNIT_DEFINES_SVH
`define FREE_LIST_POOL_ALLOCATOR_UNIT_DEFINES_SVH

// checked only out of reset
`define FLPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FLPA_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/flpa_pkg.sv */
// ----------------------------------------------------------------------------
// flpa_pkg
// field widths and codes of the free list pool allocator
// ----------------------------------------------------------------------------
package flpa_pkg;

	localparam int unsigned KIND_W     = 2;
	localparam int unsigned POOL_W     = 7;
	localparam int unsigned NODE_W     = 6;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned COUNT_W    = 7;
	localparam int unsigned RESET_POOL = 64;

	// command codes
	localparam logic [KIND_W-1:0] KIND_INIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_START  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_DECIDE = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_DENIED = 2'd3;

endpackage

/* rtl/flpa_ram.sv */
// ----------------------------------------------------------------------------
// flpa_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module flpa_ram #(
	parameter int unsigned WIDTH = 7,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/free_list_pool_allocator_unit.sv */
// ----------------------------------------------------------------------------
// free_list_pool_allocator_unit
// slot pool with a free list, an allocated list and a stepwise filter walk
// ----------------------------------------------------------------------------
// One command word is taken when start is high and busy is low; every
// command gives exactly one result word, shown for a single cycle with
// done high, and the receiver cannot hold it off, so it must take it then.
// Init, start-walk and any refused command finish in S_IDLE; allocate and
// a filter decision pass through S_READ, as they read one link from the
// next-pointer ram; a decision that releases a node behind a kept one also
// passes S_FIX, as it writes two links through the single ram write port.
// The result appears in the cycle after the command finishes, and a new
// command may be taken in that same cycle; after a release behind a kept
// node the result is shown while the predecessor link is written, and busy
// stays high through that write. Init needs no clearing pass at any pool
// size or after reset: a fresh-slot mark stands in for the chained links.
// pool_size is to be written through cfg_we/cfg_wdata only while idle,
// which the block does not enforce; it takes effect at the next init.
// ----------------------------------------------------------------------------
module free_list_pool_allocator_unit #(
	parameter int unsigned MAX_SLOTS = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [flpa_pkg::POOL_W-1:0]    cfg_wdata,
	input  logic                           start,
	output logic                           busy,
	input  logic [flpa_pkg::KIND_W-1:0]    kind,
	input  logic                           keep,
	output logic                           done,
	output logic [flpa_pkg::NODE_W-1:0]    node,
	output logic                           node_valid,
	output logic [flpa_pkg::STATUS_W-1:0]  status,
	output logic [flpa_pkg::COUNT_W-1:0]   free_count,
	output logic [flpa_pkg::COUNT_W-1:0]   allocated_count,
	output logic [flpa_pkg::COUNT_W-1:0]   kept_count
);

	import flpa_pkg::*;
	`include "free_list_pool_allocator_unit_defines.svh"

	// slot index width and pointer width (pointer also holds the null value)
	localparam int unsigned IW = $clog2(MAX_SLOTS);
	localparam int unsigned PW = $clog2(MAX_SLOTS + 1);
	localparam logic [PW-1:0] NIL   = PW'(MAX_SLOTS);
	localparam logic [PW-1:0] RST_N = PW'((RESET_POOL > MAX_SLOTS) ? MAX_SLOTS : RESET_POOL);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_FIX
	} state_t;

	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic                keep_q;
	logic [IW-1:0]       rd_addr_q;
	logic [POOL_W-1:0]   pool_size_q;

	// list heads and walk position
	logic [PW-1:0]       free_head_q;
	logic [PW-1:0]       alloc_head_q;
	logic [PW-1:0]       walk_cur_q;
	logic [PW-1:0]       walk_prev_q;
	logic                walk_active_q;

	// list lengths
	logic [PW-1:0]       free_total_q;
	logic [PW-1:0]       alloc_total_q;
	logic [PW-1:0]       kept_total_q;

	// slots at or above the fresh mark are untouched since init: their link
	// is the ascending chain of the last init, whatever the ram holds
	logic [PW-1:0]       fresh_q;
	logic [PW-1:0]       init_n_q;

	// result word
	logic                done_q;
	logic [IW-1:0]       node_q;
	logic                node_valid_q;
	logic [STATUS_W-1:0] status_q;

	logic                accept;
	logic [PW-1:0]       n_eff;
	logic [IW-1:0]       rd_addr;
	logic [PW-1:0]       ram_rdata;
	logic [PW-1:0]       rd_ext;
	logic [PW-1:0]       virt_next;
	logic [PW-1:0]       virt_link;
	logic [PW-1:0]       link;
	logic                mem_we;
	logic [IW-1:0]       mem_waddr;
	logic [PW-1:0]       mem_wdata;
	logic [PW:0]         total_sum;
	logic [PW:0]         init_n_ext;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;

	// pool size clamped into one .. MAX_SLOTS
	always_comb begin
		if (pool_size_q == '0) begin
			n_eff = PW'(1);
		end else if (32'(pool_size_q) > MAX_SLOTS) begin
			n_eff = NIL;
		end else begin
			n_eff = PW'(pool_size_q);
		end
	end

	// link read: free head for allocate, walk node for a decision
	assign rd_addr = (kind == KIND_DECIDE) ? walk_cur_q[IW-1:0] : free_head_q[IW-1:0];

	assign rd_ext    = PW'(rd_addr_q);
	assign virt_next = rd_ext + PW'(1);
	assign virt_link = (virt_next < init_n_q) ? virt_next : NIL;
	assign link      = (rd_ext >= fresh_q) ? virt_link : ram_rdata;

	// write-back: one link per cycle
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_addr_q;
		mem_wdata = alloc_head_q;
		unique case (state_q)
			S_READ: begin
				if (kind_q == KIND_ALLOC) begin
					// popped slot now heads the allocated list
					mem_we = 1'b1;
				end else if (!keep_q) begin
					// released node goes onto the free list
					mem_we    = 1'b1;
					mem_wdata = free_head_q;
				end
			end
			S_FIX: begin
				// predecessor skips the released node
				mem_we    = 1'b1;
				mem_waddr = walk_prev_q[IW-1:0];
				mem_wdata = walk_cur_q;
			end
			default: begin
			end
		endcase
	end

	flpa_ram #(
		.WIDTH (PW),
		.DEPTH (MAX_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= KIND_INIT;
			keep_q        <= 1'b0;
			rd_addr_q     <= '0;
			pool_size_q   <= POOL_W'(RESET_POOL);
			free_head_q   <= '0;
			alloc_head_q  <= NIL;
			walk_cur_q    <= NIL;
			walk_prev_q   <= NIL;
			walk_active_q <= 1'b0;
			free_total_q  <= RST_N;
			alloc_total_q <= '0;
			kept_total_q  <= '0;
			fresh_q       <= '0;
			init_n_q      <= RST_N;
			done_q        <= 1'b0;
			node_q        <= '0;
			node_valid_q  <= 1'b0;
			status_q      <= STAT_OK;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				pool_size_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q    <= kind;
						keep_q    <= keep;
						rd_addr_q <= rd_addr;
						unique case (kind)
							KIND_INIT: begin
								free_head_q   <= '0;
								alloc_head_q  <= NIL;
								walk_cur_q    <= NIL;
								walk_prev_q   <= NIL;
								walk_active_q <= 1'b0;
								free_total_q  <= n_eff;
								alloc_total_q <= '0;
								kept_total_q  <= '0;
								fresh_q       <= '0;
								init_n_q      <= n_eff;
								done_q        <= 1'b1;
								node_q        <= '0;
								node_valid_q  <= 1'b0;
								status_q      <= STAT_OK;
							end
							KIND_ALLOC: begin
								if (walk_active_q || free_head_q == NIL) begin
									done_q       <= 1'b1;
									node_q       <= '0;
									node_valid_q <= 1'b0;
									status_q     <= walk_active_q ? STAT_DENIED : STAT_FULL;
								end else begin
									state_q <= S_READ;
								end
							end
							KIND_START: begin
								done_q <= 1'b1;
								if (walk_active_q) begin
									node_q       <= '0;
									node_valid_q <= 1'b0;
									status_q     <= STAT_DENIED;
								end else begin
									kept_total_q <= '0;
									walk_prev_q  <= NIL;
									walk_cur_q   <= alloc_head_q;
									if (alloc_head_q == NIL) begin
										// nothing allocated: walk over at once
										node_q       <= '0;
										node_valid_q <= 1'b0;
										status_q     <= STAT_DONE;
									end else begin
										walk_active_q <= 1'b1;
										node_q        <= alloc_head_q[IW-1:0];
										node_valid_q  <= 1'b1;
										status_q      <= STAT_OK;
									end
								end
							end
							KIND_DECIDE: begin
								if (!walk_active_q || walk_cur_q == NIL) begin
									done_q       <= 1'b1;
									node_q       <= '0;
									node_valid_q <= 1'b0;
									status_q     <= STAT_DENIED;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (kind_q == KIND_ALLOC) begin
						free_head_q  <= link;
						alloc_head_q <= rd_ext;
						if (free_total_q != '0) begin
							free_total_q <= free_total_q - PW'(1);
						end
						alloc_total_q <= alloc_total_q + PW'(1);
						if (rd_ext == fresh_q) begin
							fresh_q <= fresh_q + PW'(1);
						end
						node_q       <= rd_addr_q;
						node_valid_q <= 1'b1;
						status_q     <= STAT_OK;
					end else begin
						if (keep_q) begin
							walk_prev_q  <= rd_ext;
							kept_total_q <= kept_total_q + PW'(1);
						end else begin
							if (walk_prev_q == NIL) begin
								alloc_head_q <= link;
							end else begin
								// predecessor link still to write
								state_q <= S_FIX;
							end
							free_head_q  <= rd_ext;
							free_total_q <= free_total_q + PW'(1);
							if (alloc_total_q != '0) begin
								alloc_total_q <= alloc_total_q - PW'(1);
							end
						end
						walk_cur_q <= link;
						if (link == NIL) begin
							walk_active_q <= 1'b0;
							node_q        <= '0;
							node_valid_q  <= 1'b0;
							status_q      <= STAT_DONE;
						end else begin
							node_q       <= link[IW-1:0];
							node_valid_q <= 1'b1;
							status_q     <= STAT_OK;
						end
					end
				end
				S_FIX: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign node            = NODE_W'(node_q);
	assign node_valid      = node_valid_q;
	assign status          = status_q;
	assign free_count      = COUNT_W'(free_total_q);
	assign allocated_count = COUNT_W'(alloc_total_q);
	assign kept_count      = COUNT_W'(kept_total_q);

	// every slot of the pool sits on exactly one list
	assign total_sum  = (PW + 1)'(free_total_q) + (PW + 1)'(alloc_total_q);
	assign init_n_ext = (PW + 1)'(init_n_q);

	`FLPA_ASSERT(a_list_totals, total_sum == init_n_ext, "list lengths do not add up to the pool")
	`FLPA_ASSERT(a_free_empty, (free_head_q == NIL) == (free_total_q == '0), "free head and free count disagree")
	`FLPA_ASSERT(a_walk_node, walk_active_q |-> walk_cur_q != NIL, "active walk without a current node")
	`FLPA_ASSERT(a_fresh_mark, fresh_q <= init_n_q, "fresh slot mark beyond the pool")
	`FLPA_ASSERT(a_done_source, done |-> $past(state_q == S_READ) || $past(accept), "result word without a command")
	`FLPA_ASSERT_RST(a_reset_quiet, !arst_n |=> !busy && !done, "activity during reset")

endmodule

/* bench/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for free_list_pool_allocator_unit
// ----------------------------------------------------------------------------
// Drives command words (init, allocate, start walk, filter decision) through
// the start/busy handshake with bursty pacing. A slot tracker class keeps its
// own copy of the link store, both list heads, the walk pointers and the
// counters. It works out the result word of every accepted command and
// compares it, field by field, with the word shown under done. pool_size is
// rewritten between phases, while the block is idle, over its whole range.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import flpa_pkg::*;

	localparam int unsigned SLOTS      = 64;
	localparam logic [6:0]  NIL        = 7'(SLOTS);
	localparam int unsigned STALL_MAX  = 1000;
	localparam int unsigned WORDS_GOAL = 600;

	// one expected result word
	typedef struct packed {
		logic [NODE_W-1:0]   node;
		logic                valid;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  free_n;
		logic [COUNT_W-1:0]  alloc_n;
		logic [COUNT_W-1:0]  kept_n;
	} pool_word_t;

	// tracks both lists and the walk, and checks the result words
	class slot_tracker;
		logic [POOL_W-1:0] pool_size;
		logic [6:0]        link_tab [SLOTS];
		logic [6:0]        free_head;
		logic [6:0]        alloc_head;
		logic [6:0]        walk_cur;
		logic [6:0]        walk_prev;
		logic              walk_on;
		logic [6:0]        free_total;
		logic [6:0]        alloc_total;
		logic [6:0]        kept_total;
		pool_word_t        due_words [$];
		int                mismatches;

		function new();
			pool_size  = POOL_W'(RESET_POOL);
			mismatches = 0;
			rebuild_pool();
		endfunction

		// chain the free list in ascending order, drop the allocated list
		function void rebuild_pool();
			int n;
			n = pool_size;
			if (n == 0)
				n = 1;
			if (n > SLOTS)
				n = SLOTS;
			for (int i = 0; i < SLOTS; i++)
				link_tab[i] = (i + 1 < n) ? 7'(i + 1) : NIL;
			free_head   = '0;
			alloc_head  = NIL;
			walk_cur    = NIL;
			walk_prev   = NIL;
			walk_on     = 1'b0;
			free_total  = 7'(n);
			alloc_total = '0;
			kept_total  = '0;
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		// apply one accepted command and queue the word it must produce
		function logic [STATUS_W-1:0] note_command(logic [KIND_W-1:0] k, logic kp);
			pool_word_t w;
			logic [6:0] s;
			logic [6:0] cur;
			logic [6:0] succ;
			w = '0;
			w.status = STAT_OK;
			case (k)
				KIND_INIT: begin
					rebuild_pool();
				end
				KIND_ALLOC: begin
					if (walk_on) begin
						w.status = STAT_DENIED;
					end else if (free_head >= NIL) begin
						w.status = STAT_FULL;
					end else begin
						s = free_head;
						free_head = link_tab[s[5:0]];
						link_tab[s[5:0]] = alloc_head;
						alloc_head = s;
						if (free_total > 0)
							free_total--;
						alloc_total++;
						w.node  = s[5:0];
						w.valid = 1'b1;
					end
				end
				KIND_START: begin
					if (walk_on) begin
						w.status = STAT_DENIED;
					end else begin
						kept_total = '0;
						walk_prev  = NIL;
						walk_cur   = alloc_head;
						if (walk_cur >= NIL) begin
							// nothing allocated: the walk is over at once
							w.status = STAT_DONE;
						end else begin
							walk_on = 1'b1;
							w.node  = walk_cur[5:0];
							w.valid = 1'b1;
						end
					end
				end
				default: begin
					if (!walk_on || walk_cur >= NIL) begin
						w.status = STAT_DENIED;
					end else begin
						cur  = walk_cur;
						succ = link_tab[cur[5:0]];
						if (kp) begin
							walk_prev = cur;
							kept_total++;
						end else begin
							// unlink and push onto the free list
							if (walk_prev >= NIL)
								alloc_head = succ;
							else
								link_tab[walk_prev[5:0]] = succ;
							link_tab[cur[5:0]] = free_head;
							free_head = cur;
							free_total++;
							if (alloc_total > 0)
								alloc_total--;
						end
						walk_cur = succ;
						if (succ >= NIL) begin
							walk_on  = 1'b0;
							w.status = STAT_DONE;
						end else begin
							w.node  = succ[5:0];
							w.valid = 1'b1;
						end
					end
				end
			endcase
			w.free_n  = free_total;
			w.alloc_n = alloc_total;
			w.kept_n  = kept_total;
			due_words.push_back(w);
			return w.status;
		endfunction

		task flag_mismatch(string what, int got, int want);
			if (mismatches < 40)
				$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
			mismatches++;
		endtask

		task check_word(pool_word_t got);
			pool_word_t want;
			if (due_words.size() == 0) begin
				flag_mismatch("result word with nothing due, node", got.node, 0);
			end else begin
				want = due_words.pop_front();
				if (got.node != want.node)
					flag_mismatch("node", got.node, want.node);
				if (got.valid != want.valid)
					flag_mismatch("node_valid", got.valid, want.valid);
				if (got.status != want.status)
					flag_mismatch("status", got.status, want.status);
				if (got.free_n != want.free_n)
					flag_mismatch("free_count", got.free_n, want.free_n);
				if (got.alloc_n != want.alloc_n)
					flag_mismatch("allocated_count", got.alloc_n, want.alloc_n);
				if (got.kept_n != want.kept_n)
					flag_mismatch("kept_count", got.kept_n, want.kept_n);
			end
		endtask
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_we     = 1'b0;
	logic [POOL_W-1:0]   cfg_wdata  = '0;
	logic                start      = 1'b0;
	logic [KIND_W-1:0]   kind       = KIND_INIT;
	logic                keep       = 1'b0;
	logic                busy;
	logic                done;
	logic [NODE_W-1:0]   node;
	logic                node_valid;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  free_count;
	logic [COUNT_W-1:0]  allocated_count;
	logic [COUNT_W-1:0]  kept_count;

	slot_tracker tracker = new();
	int          useful_words = 0;
	int          stall_cycles = 0;
	int          burst_left   = 0;

	free_list_pool_allocator_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.keep            (keep),
		.done            (done),
		.node            (node),
		.node_valid      (node_valid),
		.status          (status),
		.free_count      (free_count),
		.allocated_count (allocated_count),
		.kept_count      (kept_count)
	);

	always #4 clk = ~clk;

	// result checking and the stall watchdog
	always @(posedge clk) begin
		if (arst_n && done)
			tracker.check_word({node, node_valid, status, free_count, allocated_count,
				kept_count});
		if (done || (start && !busy))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_MAX) begin
			$display("[free_list_pool_allocator_unit] ERROR");
			$finish;
		end
	end

	// bursts of back-to-back words, then a random gap with noise on the fields
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 10);
			start <= 1'b0;
			kind  <= KIND_W'($urandom);
			keep  <= 1'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// offer one command word and hold it until busy lets it in
	task automatic send_word(input logic [KIND_W-1:0] k, input logic kp);
		logic [STATUS_W-1:0] st;
		start <= 1'b1;
		kind  <= k;
		keep  <= kp;
		do @(posedge clk); while (busy);
		st = tracker.note_command(k, kp);
		if (st != STAT_DENIED)
			useful_words++;
		pace();
	endtask

	// wait until every due word has come back and the block is idle
	task automatic settle();
		start <= 1'b0;
		while (tracker.pending() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic write_pool(input logic [POOL_W-1:0] v);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		tracker.pool_size = v;
		cfg_we <= 1'b0;
	endtask

	// allocate a run of slots, now and then past the point of a full pool
	task automatic fill_run();
		int n;
		if ($urandom_range(0, 3) == 0)
			n = tracker.free_total + 1;
		else
			n = $urandom_range(1, 8);
		repeat (n) send_word(KIND_ALLOC, 1'($urandom));
	endtask

	// a complete filter walk with a per-walk keep bias
	task automatic filter_walk();
		int keep_pct;
		int pick;
		case ($urandom_range(0, 3))
			0: keep_pct = 0;
			1: keep_pct = 100;
			2: keep_pct = 50;
			default: keep_pct = $urandom_range(0, 100);
		endcase
		if (!tracker.walk_on)
			send_word(KIND_START, 1'($urandom));
		while (tracker.walk_on) begin
			pick = $urandom_range(0, 99);
			if (pick < 3)
				send_word(KIND_ALLOC, 1'($urandom));
			else if (pick < 5)
				send_word(KIND_START, 1'($urandom));
			else if (pick < 7)
				send_word(KIND_INIT, 1'($urandom));
			else
				send_word(KIND_DECIDE, 1'($urandom_range(0, 99) < keep_pct));
		end
	endtask

	function automatic logic [POOL_W-1:0] pick_pool();
		case ($urandom_range(0, 11))
			0: return '0;
			1: return 7'd1;
			2: return 7'd64;
			3: return 7'd127;
			4: return 7'($urandom_range(65, 127));
			5: return 7'($urandom_range(13, 64));
			default: return 7'($urandom_range(2, 12));
		endcase
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty walk, refused commands, release behind a kept node
		send_word(KIND_START, 1'b0);
		send_word(KIND_DECIDE, 1'b1);
		repeat (3) send_word(KIND_ALLOC, 1'b0);
		send_word(KIND_START, 1'b1);
		send_word(KIND_ALLOC, 1'b1);
		send_word(KIND_START, 1'b0);
		send_word(KIND_DECIDE, 1'b1);
		send_word(KIND_DECIDE, 1'b0);
		send_word(KIND_DECIDE, 1'b0);
		send_word(KIND_DECIDE, 1'b0);
		// a walk that keeps the single allocated node, then init
		send_word(KIND_START, 1'b0);
		send_word(KIND_DECIDE, 1'b1);
		send_word(KIND_INIT, 1'b1);

		// single slot pool, zero acting as one, oversize acting as full size
		write_pool(7'd1);
		send_word(KIND_INIT, 1'b0);
		send_word(KIND_ALLOC, 1'b0);
		send_word(KIND_ALLOC, 1'b0);
		write_pool('0);
		send_word(KIND_INIT, 1'b0);
		send_word(KIND_ALLOC, 1'b1);
		send_word(KIND_ALLOC, 1'b1);
		write_pool(7'd127);
		send_word(KIND_INIT, 1'b0);
		send_word(KIND_ALLOC, 1'b0);
		send_word(KIND_START, 1'b0);
		send_word(KIND_DECIDE, 1'b0);

		// random phases, each with its own pool size
		while (useful_words < WORDS_GOAL) begin
			write_pool(pick_pool());
			send_word(KIND_INIT, 1'($urandom));
			repeat ($urandom_range(2, 8)) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: fill_run();
					4, 5, 6, 7: filter_walk();
					8: send_word(KIND_W'($urandom), 1'($urandom));
					default: send_word(KIND_INIT, 1'($urandom));
				endcase
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (tracker.pending() != 0)
			tracker.flag_mismatch("words still due at the end", 0, tracker.pending());
		if (tracker.mismatches == 0)
			$display("[free_list_pool_allocator_unit] OK");
		else
			$display("[free_list_pool_allocator_unit] ERROR");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/flpa_pkg.sv
rtl/flpa_ram.sv
rtl/free_list_pool_allocator_unit.sv
bench/testbench.sv
